[rtl/c_esc_pkg.sv]
// ----------------------------------------------------------------------------
// C string escape decoder package
// Shared character codes, escape phase type and state/result records.
// ----------------------------------------------------------------------------
package c_esc_pkg;

  // Character codes recognized by the decoder.
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_SEVEN  = 8'h37;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_N      = 8'h6E;
  localparam logic [7:0] CHR_R      = 8'h72;
  localparam logic [7:0] CHR_T      = 8'h74;
  localparam logic [7:0] CHR_V      = 8'h76;

  // Control bytes produced by the letter escapes.
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0B;

  // Where the decoder stands within an escape sequence.
  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,  // ordinary text
    PH_ESC  = 2'd1,  // right after a backslash
    PH_NUM2 = 2'd2,  // numeric escape, two bytes still to consume
    PH_NUM1 = 2'd3   // numeric escape, one byte still to consume
  } phase_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] octal_value;
    logic       octal_open;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_TEXT, octal_value: 8'h00, octal_open: 1'b0};

  // One decoded result and whether the byte produces it at all.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       valid;
    logic       last;
  } result_t;

endpackage

[rtl/c_esc_dec.sv]
// ----------------------------------------------------------------------------
// C string escape decoder step
// Combinational next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
module c_esc_dec (
  input  c_esc_pkg::state_t  st,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output c_esc_pkg::state_t  st_nxt,
  output c_esc_pkg::result_t res
);

  logic       is_digit;
  logic       is_octal;
  logic [7:0] letter_map;
  logic [7:0] first_value;
  logic [7:0] shifted_value;

  // Byte classification.
  assign is_digit = (in_byte >= c_esc_pkg::CHR_ZERO) && (in_byte <= c_esc_pkg::CHR_NINE);
  assign is_octal = (in_byte >= c_esc_pkg::CHR_ZERO) && (in_byte <= c_esc_pkg::CHR_SEVEN);

  // An octal digit's value is its low three bits; 8 or 9 starts at zero.
  assign first_value   = is_octal ? {5'b00000, in_byte[2:0]} : 8'h00;
  assign shifted_value = {st.octal_value[4:0], in_byte[2:0]};

  // Letter escapes that map to control bytes; anything else stands for itself.
  always_comb begin
    priority if (in_byte == c_esc_pkg::CHR_N) begin
      letter_map = c_esc_pkg::CTL_LF;
    end else if (in_byte == c_esc_pkg::CHR_R) begin
      letter_map = c_esc_pkg::CTL_CR;
    end else if (in_byte == c_esc_pkg::CHR_T) begin
      letter_map = c_esc_pkg::CTL_TAB;
    end else if (in_byte == c_esc_pkg::CHR_V) begin
      letter_map = c_esc_pkg::CTL_VT;
    end else begin
      letter_map = in_byte;
    end
  end

  // Per-phase decode.
  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (st.phase)
      c_esc_pkg::PH_TEXT: begin
        if (in_byte == c_esc_pkg::CHR_BSLASH) begin
          if (in_last) begin
            // A lone backslash at the end is dropped; an end marker remains.
            res = '{emit: 1'b1, data: 8'h00, valid: 1'b0, last: 1'b1};
          end else begin
            st_nxt.phase = c_esc_pkg::PH_ESC;
          end
        end else begin
          res = '{emit: 1'b1, data: in_byte, valid: 1'b1, last: in_last};
        end
      end
      c_esc_pkg::PH_ESC: begin
        if (is_digit) begin
          st_nxt.octal_value = first_value;
          st_nxt.octal_open  = is_octal;
          if (in_last) begin
            res = '{emit: 1'b1, data: first_value, valid: 1'b1, last: 1'b1};
          end else begin
            st_nxt.phase = c_esc_pkg::PH_NUM2;
          end
        end else begin
          res          = '{emit: 1'b1, data: letter_map, valid: 1'b1, last: in_last};
          st_nxt.phase = c_esc_pkg::PH_TEXT;
        end
      end
      c_esc_pkg::PH_NUM2, c_esc_pkg::PH_NUM1: begin
        if (st.octal_open && is_octal) begin
          st_nxt.octal_value = shifted_value;
        end else begin
          st_nxt.octal_open = 1'b0;
        end
        if ((st.phase == c_esc_pkg::PH_NUM1) || in_last) begin
          res = '{emit: 1'b1, data: st_nxt.octal_value, valid: 1'b1, last: in_last};
          st_nxt.phase = c_esc_pkg::PH_TEXT;
        end else begin
          st_nxt.phase = c_esc_pkg::PH_NUM1;
        end
      end
      default: begin
        st_nxt = c_esc_pkg::STATE_RESET;
      end
    endcase

    // The end of a string returns the decoder to its reset state.
    if (in_last) begin
      st_nxt = c_esc_pkg::STATE_RESET;
    end
  end

endmodule

[rtl/c_escape_unescaper_core.sv]
// ----------------------------------------------------------------------------
// C string escape decoder core
// Unescapes a C-style quoted string streamed one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one string byte per transaction in in_tdata,
//   with in_tlast set on the final byte of a string. The output stream gives
//   one decoded byte per transaction in out_tdata; out_tuser[0] is set when
//   the byte is real data, and out_tlast marks the end of the decoded string.
//   A transaction with out_tuser[0] low carries only the end mark (a trailing
//   lone backslash) and its data is zero.
//   A backslash and the first two bytes of a numeric escape produce no output;
//   a letter escape yields its byte with its second byte, and a numeric escape
//   yields one byte with its third byte, or earlier when the string ends.
//   A byte accepted into the input register is decoded there and its
//   result is registered before it is presented on the output.
//   Throughput is one byte per cycle while the receiver takes results,
//   set by the single decode step between the input and result registers.
//   Reset clears both stages and returns the decoder to plain text.
//   When the receiver stalls, the result register holds its transaction and
//   the input register still takes a byte if it is empty or produces no
//   result; otherwise in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module c_escape_unescaper_core (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  // Result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [0:0] out_tuser,  // [0] out_valid
  output logic       out_tlast
);

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  c_esc_pkg::state_t   state_r;
  c_esc_pkg::state_t   state_nxt;
  c_esc_pkg::result_t  dec_res;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_flag_r;
  logic                out_last_r;
  logic                out_free;
  logic                s1_adv;

  // Decode step for the byte held in the input register.
  c_esc_dec u_dec (
    .st      (state_r),
    .in_byte (s1_byte_r),
    .in_last (s1_last_r),
    .st_nxt  (state_nxt),
    .res     (dec_res)
  );

  // Handshake control between the two stages.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!dec_res.emit || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Escape state advances once per decoded byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c_esc_pkg::STATE_RESET;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && dec_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && dec_res.emit) begin
      out_byte_r <= dec_res.data;
      out_flag_r <= dec_res.valid;
      out_last_r <= dec_res.last;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tuser[0] = out_flag_r;
  assign out_tlast    = out_last_r;

`ifndef SYNTHESIS
  // A result without a data byte only marks the end of a string.
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && (out_tdata == 8'h00)))
    else $error("end-only result without last or with nonzero data");

  // Finishing a string leaves the decoder in plain text.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (state_r.phase == c_esc_pkg::PH_TEXT && !state_r.octal_open))
    else $error("decoder state not cleared after end of string");

  // Input backpressure only when both stages are occupied.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  // Stage-one data that produces a result is never discarded.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && dec_res.emit && !out_free) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("pending byte lost while the result register was full");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// C string escape decoder testbench
// Streams quoted strings into the decoder under several sender and receiver
// idling patterns, including one long receiver hold-off. A predictor that
// tracks the escape state works out each decoded transaction. Every
// transaction taken from the result stream is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  // One decoded transaction as it appears on the result stream.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } decoded_t;

  // One row of the directed stimulus; the expected result is typed in
  // only where has_typed is set.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
    logic       has_typed;
    logic [7:0] exp_data;
    logic       exp_valid;
    logic       exp_last;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic       out_tlast;

  // Predictor state.
  c_esc_pkg::phase_t pred_phase;
  logic [7:0]        pred_octal;
  logic              pred_open;

  decoded_t   pending_bytes[$];
  int         mismatches;
  int         quiet_cycles;
  int         idle_pct;
  int         stall_pct;
  bit         hold_req;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // Plain bytes, including the extremes of the byte range.
    '{8'h41,                 1'b0, 1'b1, 8'h41,                 1'b1, 1'b0},
    '{8'h00,                 1'b0, 1'b1, 8'h00,                 1'b1, 1'b0},
    '{8'hFF,                 1'b1, 1'b1, 8'hFF,                 1'b1, 1'b1},
    // Letter escapes.
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{c_esc_pkg::CHR_N,      1'b0, 1'b1, c_esc_pkg::CTL_LF,     1'b1, 1'b0},
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{c_esc_pkg::CHR_R,      1'b0, 1'b1, c_esc_pkg::CTL_CR,     1'b1, 1'b0},
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{c_esc_pkg::CHR_T,      1'b0, 1'b1, c_esc_pkg::CTL_TAB,    1'b1, 1'b0},
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{c_esc_pkg::CHR_V,      1'b0, 1'b1, c_esc_pkg::CTL_VT,     1'b1, 1'b0},
    // Escaped backslash that ends the string.
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{c_esc_pkg::CHR_BSLASH, 1'b1, 1'b1, c_esc_pkg::CHR_BSLASH, 1'b1, 1'b1},
    // Trailing lone backslash gives an end-only transaction.
    '{c_esc_pkg::CHR_BSLASH, 1'b1, 1'b1, 8'h00,                 1'b0, 1'b1},
    // Octal value wider than 8 bits.
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{8'h34,                 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{8'h30,                 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{8'h31,                 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    // Numeric escape that opens with a non-octal digit.
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{c_esc_pkg::CHR_NINE,   1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{8'h31,                 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{8'h32,                 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    // String that ends inside a numeric escape.
    '{c_esc_pkg::CHR_BSLASH, 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{8'h31,                 1'b0, 1'b0, 8'h00,                 1'b0, 1'b0},
    '{8'h32,                 1'b1, 1'b0, 8'h00,                 1'b0, 1'b0}
  };

  c_escape_unescaper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic is_octal_digit(input logic [7:0] b);
    return (b >= c_esc_pkg::CHR_ZERO) && (b <= c_esc_pkg::CHR_SEVEN);
  endfunction

  // Advances the predicted escape state by one byte. Returns 1 when the
  // byte produces a decoded transaction, which is left in res.
  function automatic logic unescape_step(input logic [7:0] b, input logic last,
                                         output decoded_t res);
    logic       emit;
    logic [7:0] letter;
    emit = 1'b0;
    res  = '0;
    case (pred_phase)
      c_esc_pkg::PH_TEXT: begin
        if (b == c_esc_pkg::CHR_BSLASH) begin
          if (last) begin
            res  = '{data: 8'h00, valid: 1'b0, last: 1'b1};
            emit = 1'b1;
          end else begin
            pred_phase = c_esc_pkg::PH_ESC;
          end
        end else begin
          res  = '{data: b, valid: 1'b1, last: last};
          emit = 1'b1;
        end
      end
      c_esc_pkg::PH_ESC: begin
        if (b >= c_esc_pkg::CHR_ZERO && b <= c_esc_pkg::CHR_NINE) begin
          // A digit opens a numeric escape; 8 and 9 start it at zero and stop later digits adding to it.
          if (is_octal_digit(b)) begin
            pred_octal = {5'b0, b[2:0]};
            pred_open  = 1'b1;
          end else begin
            pred_octal = 8'h00;
            pred_open  = 1'b0;
          end
          if (last) begin
            res  = '{data: pred_octal, valid: 1'b1, last: 1'b1};
            emit = 1'b1;
          end else begin
            pred_phase = c_esc_pkg::PH_NUM2;
          end
        end else begin
          case (b)
            c_esc_pkg::CHR_N: letter = c_esc_pkg::CTL_LF;
            c_esc_pkg::CHR_R: letter = c_esc_pkg::CTL_CR;
            c_esc_pkg::CHR_T: letter = c_esc_pkg::CTL_TAB;
            c_esc_pkg::CHR_V: letter = c_esc_pkg::CTL_VT;
            default:          letter = b;
          endcase
          res        = '{data: letter, valid: 1'b1, last: last};
          emit       = 1'b1;
          pred_phase = c_esc_pkg::PH_TEXT;
        end
      end
      default: begin
        // Later bytes of a numeric escape; only the low 8 bits are kept.
        if (pred_open && is_octal_digit(b)) begin
          pred_octal = {pred_octal[4:0], b[2:0]};
        end else begin
          pred_open = 1'b0;
        end
        if (pred_phase == c_esc_pkg::PH_NUM1 || last) begin
          res        = '{data: pred_octal, valid: 1'b1, last: last};
          emit       = 1'b1;
          pred_phase = c_esc_pkg::PH_TEXT;
        end else begin
          pred_phase = c_esc_pkg::PH_NUM1;
        end
      end
    endcase
    // Any final byte returns the decoder to plain text.
    if (last) begin
      pred_phase = c_esc_pkg::PH_TEXT;
      pred_octal = 8'h00;
      pred_open  = 1'b0;
    end
    return emit;
  endfunction

  // Offers one byte after a random gap and records its expected result
  // once the transaction is accepted. Starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic has_typed, input decoded_t typed_res);
    decoded_t res;
    logic     emit;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    emit = unescape_step(b, last, res);
    if (has_typed) begin
      pending_bytes.push_back(typed_res);
    end else if (emit) begin
      pending_bytes.push_back(res);
    end
    @(negedge clk);
  endtask

  // Builds one string, mostly well-formed escapes with random content,
  // and sends it with the last flag on its final byte.
  task automatic send_string(inout int sent);
    logic [7:0] str[$];
    int         len;
    int         pick;
    int         k;
    len = $urandom_range(1, 10);
    while (str.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        str.push_back(8'($urandom_range(255)));
      end else if (pick < 55) begin
        str.push_back(c_esc_pkg::CHR_BSLASH);
        case ($urandom_range(5))
          0:       str.push_back(c_esc_pkg::CHR_N);
          1:       str.push_back(c_esc_pkg::CHR_R);
          2:       str.push_back(c_esc_pkg::CHR_T);
          3:       str.push_back(c_esc_pkg::CHR_V);
          4:       str.push_back(c_esc_pkg::CHR_BSLASH);
          default: str.push_back(8'($urandom_range(255)));
        endcase
      end else if (pick < 90) begin
        str.push_back(c_esc_pkg::CHR_BSLASH);
        str.push_back(8'($urandom_range(c_esc_pkg::CHR_ZERO, c_esc_pkg::CHR_NINE)));
        for (k = 0; k < 2; k++) begin
          if ($urandom_range(99) < 75) begin
            str.push_back(8'($urandom_range(c_esc_pkg::CHR_ZERO, c_esc_pkg::CHR_SEVEN)));
          end else begin
            str.push_back(8'($urandom_range(255)));
          end
        end
      end else begin
        str.push_back(c_esc_pkg::CHR_BSLASH);
      end
    end
    // Sometimes cut the string so that it ends inside an escape.
    if ($urandom_range(99) < 30 && str.size() > 1) begin
      void'(str.pop_back());
    end
    for (k = 0; k < str.size(); k++) begin
      send_byte(str[k], k == str.size() - 1, 1'b0, '0);
      sent++;
    end
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall,
                           input int num_items);
    int sent;
    sent      = 0;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    while (sent < num_items) send_string(sent);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result transaction: out_byte=%02h out_valid=%0b out_last=%0b",
               out_tdata, out_tuser[0], out_tlast);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want.data, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.valid) begin
          $error("out_valid mismatch: expected %0b, actual %0b", want.valid, out_tuser[0]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither stream moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin : stimulus
    int i;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tlast     = 1'b0;
    hold_req     = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    pred_phase   = c_esc_pkg::PH_TEXT;
    pred_octal   = 8'h00;
    pred_open    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_byte(directed_rows[i].in_byte, directed_rows[i].in_last,
                directed_rows[i].has_typed,
                '{data:  directed_rows[i].exp_data,
                  valid: directed_rows[i].exp_valid,
                  last:  directed_rows[i].exp_last});
    end

    // Random strings under each idling pattern.
    run_phase(0, 0, 300);
    run_phase(76, 0, 300);
    run_phase(0, 76, 300);
    run_phase(24, 24, 300);

    // Long receiver hold-off while the sender keeps offering bytes.
    hold_req = 1'b1;
    run_phase(0, 0, 100);
    in_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
